>>> rtl/core/prb_pkg.sv
// ----------------------------------------------------------------------------
// prb_pkg: shared types and constants for the Polak-Ribiere beta reduction
// Fixed field widths, default sizes, accumulator opcodes and the control
// and status bundles passed between the sequencer and its arithmetic units.
// ----------------------------------------------------------------------------
package prb_pkg;

    // Default sizes handed to the top-level parameters
    localparam int COMPONENT_WIDTH   = 32;
    localparam int ACCUMULATOR_WIDTH = 64;

    // Components per force vector (x, y, z, w)
    localparam int NUM_COMP = 4;

    // Denominator floor register, unsigned Q31.32 (reset is about 1e-5)
    localparam int                     FLOOR_WIDTH = 63;
    localparam logic [FLOOR_WIDTH-1:0] FLOOR_RESET = 63'd42950;

    // Result format: signed Q16.16
    localparam int                    BETA_WIDTH = 32;
    localparam int                    FRAC_BITS  = 16;
    localparam logic [BETA_WIDTH-1:0] BETA_MAX   = 32'h7FFF_FFFF;
    localparam logic [BETA_WIDTH-1:0] BETA_MIN   = 32'h8000_0000;

    // Accumulator operation applied to one product
    typedef enum logic [1:0] {
        ACC_NUM_ADD,
        ACC_NUM_SUB,
        ACC_DEN_ADD
    } t_acc_op;

    // Sequencer to multiply-accumulate unit
    typedef struct packed {
        logic    vld;
        logic    clr;
        t_acc_op op;
    } t_mac_ctl;

    // Divider status back to the sequencer
    typedef struct packed {
        logic done;
        logic big;
    } t_div_stat;

endpackage

>>> rtl/core/prb_mac.sv
// ----------------------------------------------------------------------------
// prb_mac: shared multiplier with saturating accumulators
// One signed product per cycle is registered, then added to or subtracted
// from the numerator, or added to the denominator, with clamping.
// ----------------------------------------------------------------------------
module prb_mac #(
    parameter int COMPONENT_WIDTH   = prb_pkg::COMPONENT_WIDTH,
    parameter int ACCUMULATOR_WIDTH = prb_pkg::ACCUMULATOR_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  prb_pkg::t_mac_ctl                   i_ctl,
    input  logic signed [COMPONENT_WIDTH-1:0]   i_op_a,
    input  logic signed [COMPONENT_WIDTH-1:0]   i_op_b,
    output logic signed [ACCUMULATOR_WIDTH-1:0] o_num,
    output logic signed [ACCUMULATOR_WIDTH-1:0] o_den,
    output logic                                o_ovf
);

    localparam int CW = COMPONENT_WIDTH;
    localparam int AW = ACCUMULATOR_WIDTH;
    localparam int PW = 2 * CW;
    localparam int SW = ((AW > PW) ? AW : PW) + 1;

    localparam logic signed [SW-1:0] ACC_HI = {{(SW-AW+1){1'b0}}, {(AW-1){1'b1}}};
    localparam logic signed [SW-1:0] ACC_LO = {{(SW-AW+1){1'b1}}, {(AW-1){1'b0}}};

    logic signed [PW-1:0] r_prod;
    prb_pkg::t_acc_op     r_prod_op;
    logic                 r_prod_vld;
    logic signed [AW-1:0] r_num;
    logic signed [AW-1:0] r_den;
    logic                 r_ovf;

    logic signed [AW-1:0] acc_sel;
    logic signed [SW-1:0] sum;
    logic signed [AW-1:0] n_acc;
    logic                 sat_hit;

    // Pick the target accumulator and form the wide sum
    always_comb begin
        acc_sel = (r_prod_op == prb_pkg::ACC_DEN_ADD) ? r_den : r_num;
        if (r_prod_op == prb_pkg::ACC_NUM_SUB) begin
            sum = SW'(acc_sel) - SW'(r_prod);
        end else begin
            sum = SW'(acc_sel) + SW'(r_prod);
        end
    end

    // Clamp to the accumulator range
    always_comb begin
        sat_hit = 1'b0;
        n_acc   = sum[AW-1:0];
        if (sum > ACC_HI) begin
            sat_hit = 1'b1;
            n_acc   = ACC_HI[AW-1:0];
        end else if (sum < ACC_LO) begin
            sat_hit = 1'b1;
            n_acc   = ACC_LO[AW-1:0];
        end
    end

    // Product register, no reset on payload
    always_ff @(posedge i_clk) begin
        r_prod <= PW'(i_op_a) * PW'(i_op_b);
    end

    // Product tag and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
            r_prod_op  <= prb_pkg::ACC_NUM_ADD;
            r_num      <= '0;
            r_den      <= '0;
            r_ovf      <= 1'b0;
        end else begin
            r_prod_vld <= i_ctl.vld;
            r_prod_op  <= i_ctl.op;
            if (i_ctl.clr) begin
                r_num <= '0;
                r_den <= '0;
                r_ovf <= 1'b0;
            end else if (r_prod_vld) begin
                if (r_prod_op == prb_pkg::ACC_DEN_ADD) begin
                    r_den <= n_acc;
                end else begin
                    r_num <= n_acc;
                end
                if (sat_hit) begin
                    r_ovf <= 1'b1;
                end
            end
        end
    end

    assign o_num = r_num;
    assign o_den = r_den;
    assign o_ovf = r_ovf;

endmodule

>>> rtl/core/prb_div.sv
// ----------------------------------------------------------------------------
// prb_div: restoring divider, one quotient bit per cycle
// Computes floor(mag * 2^16 / den) as a 32-bit quotient and flags a
// quotient that would need more than 32 bits.
// ----------------------------------------------------------------------------
module prb_div #(
    parameter int ACCUMULATOR_WIDTH = prb_pkg::ACCUMULATOR_WIDTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic [ACCUMULATOR_WIDTH-1:0]          i_mag,
    input  logic [ACCUMULATOR_WIDTH-1:0]          i_den,
    output prb_pkg::t_div_stat                    o_stat,
    output logic [prb_pkg::BETA_WIDTH-1:0]        o_quot
);

    localparam int AW    = ACCUMULATOR_WIDTH;
    localparam int QW    = prb_pkg::BETA_WIDTH;
    localparam int FB    = prb_pkg::FRAC_BITS;
    localparam int CNT_W = $clog2(QW);

    logic [AW-1:0]    r_rem;
    logic [AW-1:0]    r_den;
    logic [QW-1:0]    r_low;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic             r_big;

    logic [AW-1:0] rem_sh;
    logic          rem_ge;

    // Shift in the next dividend bit and trial-subtract
    always_comb begin
        rem_sh = {r_rem[AW-2:0], r_low[QW-1]};
        rem_ge = (rem_sh >= r_den);
    end

    // Iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: load on start, then one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_mag >> FB;
            r_low <= {i_mag[FB-1:0], {(QW-FB){1'b0}}};
            r_den <= i_den;
            r_big <= ((i_mag >> FB) >= i_den);
        end else if (r_busy) begin
            r_rem <= rem_ge ? (rem_sh - r_den) : rem_sh;
            r_low <= {r_low[QW-2:0], rem_ge};
        end
    end

    assign o_stat = {r_done, r_big};
    assign o_quot = r_low;

endmodule

>>> rtl/core/polak_ribiere_beta_reduction.sv
// ----------------------------------------------------------------------------
// polak_ribiere_beta_reduction: Polak-Ribiere beta over a set of atoms
// Accumulates sum(f.f) - sum(g.f) and sum(g.g) with saturation and emits
// beta = numerator / denominator in signed Q16.16 on the last atom.
// ----------------------------------------------------------------------------
// Each atom transaction carries four current-force and four previous-force
// components; one shared multiplier forms the twelve products one per cycle,
// so an atom holds the input through accept, the twelve products and one
// drain state, and the next atom is taken back in idle. The last atom of a
// set then adds prep and load steps, a bit-serial division and an emit step.
// A denominator at or below the floor register gives beta 0; a quotient
// outside Q16.16 range clamps and sets tuser, as does an accumulator
// overflow. The result sits in an output register, so the next atom may be
// accepted while it waits to be taken.
// ----------------------------------------------------------------------------
module polak_ribiere_beta_reduction #(
    parameter int COMPONENT_WIDTH   = prb_pkg::COMPONENT_WIDTH,
    parameter int ACCUMULATOR_WIDTH = prb_pkg::ACCUMULATOR_WIDTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Denominator floor register
    input  logic                                  i_cfg_wr_en,
    input  logic [prb_pkg::FLOOR_WIDTH-1:0]       i_cfg_wr_data,
    // Atom stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata, low to high: force_x, force_y, force_z, force_w,
    //                     prev_x, prev_y, prev_z, prev_w
    input  logic [2*prb_pkg::NUM_COMP*COMPONENT_WIDTH-1:0] s_axis_tdata,
    input  logic                                  s_axis_tlast,  // last_atom
    // Result stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [prb_pkg::BETA_WIDTH-1:0]        m_axis_tdata,  // beta
    output logic                                  m_axis_tuser   // saturated
);

    localparam int CW     = COMPONENT_WIDTH;
    localparam int AW     = ACCUMULATOR_WIDTH;
    localparam int NC     = prb_pkg::NUM_COMP;
    localparam int FW     = prb_pkg::FLOOR_WIDTH;
    localparam int QW     = prb_pkg::BETA_WIDTH;
    localparam int NSTEP  = 3 * NC;
    localparam int STEP_W = $clog2(NSTEP);
    localparam int IDX_W  = $clog2(NC);
    localparam int CMP_W  = (AW > FW) ? AW : FW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_PREP,
        S_LOAD,
        S_DIV,
        S_EMIT
    } t_state;

    t_state                r_state;
    logic signed [CW-1:0]  r_f [NC];
    logic signed [CW-1:0]  r_g [NC];
    logic                  r_last;
    logic [STEP_W-1:0]     r_step;
    logic [FW-1:0]         r_floor;
    logic [AW-1:0]         r_mag;
    logic [AW-1:0]         r_den;
    logic                  r_neg;
    logic                  r_den_ok;
    logic                  r_ovf;
    logic                  r_out_vld;
    logic [QW-1:0]         r_beta;
    logic                  r_sat;

    prb_pkg::t_mac_ctl     mac_ctl;
    logic signed [CW-1:0]  op_a;
    logic signed [CW-1:0]  op_b;
    logic signed [AW-1:0]  mac_num;
    logic signed [AW-1:0]  mac_den;
    logic                  mac_ovf;
    prb_pkg::t_div_stat    div_stat;
    logic [QW-1:0]         div_quot;
    logic [IDX_W-1:0]      comp_idx;
    logic [1:0]            grp;
    logic                  den_ok;
    logic [AW-1:0]         num_mag;
    logic                  out_free;
    logic [QW-1:0]         n_beta;
    logic                  n_sat;

    // Step decode: group 0 is f.f, group 1 is g.f, group 2 is g.g
    assign comp_idx = r_step[IDX_W-1:0];
    assign grp      = 2'(r_step >> IDX_W);

    // Operand select and accumulator command
    always_comb begin
        mac_ctl.vld = (r_state == S_MAC);
        mac_ctl.clr = (r_state == S_PREP);
        case (grp)
            2'd0: begin
                mac_ctl.op = prb_pkg::ACC_NUM_ADD;
                op_a       = r_f[comp_idx];
                op_b       = r_f[comp_idx];
            end
            2'd1: begin
                mac_ctl.op = prb_pkg::ACC_NUM_SUB;
                op_a       = r_g[comp_idx];
                op_b       = r_f[comp_idx];
            end
            default: begin
                mac_ctl.op = prb_pkg::ACC_DEN_ADD;
                op_a       = r_g[comp_idx];
                op_b       = r_g[comp_idx];
            end
        endcase
    end

    prb_mac #(
        .COMPONENT_WIDTH   (CW),
        .ACCUMULATOR_WIDTH (AW)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_op_a  (op_a),
        .i_op_b  (op_b),
        .o_num   (mac_num),
        .o_den   (mac_den),
        .o_ovf   (mac_ovf)
    );

    prb_div #(
        .ACCUMULATOR_WIDTH (AW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_LOAD),
        .i_mag   (r_mag),
        .i_den   (r_den),
        .o_stat  (div_stat),
        .o_quot  (div_quot)
    );

    // Denominator check and numerator magnitude
    always_comb begin
        den_ok  = !mac_den[AW-1] && (mac_den != '0) &&
                  (CMP_W'($unsigned(mac_den)) > CMP_W'(r_floor));
        num_mag = mac_num[AW-1] ? AW'(-mac_num) : $unsigned(mac_num);
    end

    // Clamp the quotient to Q16.16 and apply the sign
    always_comb begin
        n_beta = '0;
        n_sat  = r_ovf;
        if (r_den_ok) begin
            if (r_neg) begin
                if (div_stat.big || (div_quot > prb_pkg::BETA_MIN)) begin
                    n_beta = prb_pkg::BETA_MIN;
                    n_sat  = 1'b1;
                end else begin
                    n_beta = QW'(-div_quot);
                end
            end else begin
                if (div_stat.big || (div_quot > prb_pkg::BETA_MAX)) begin
                    n_beta = prb_pkg::BETA_MAX;
                    n_sat  = 1'b1;
                end else begin
                    n_beta = div_quot;
                end
            end
        end
    end

    assign out_free = !r_out_vld || m_axis_tready;

    // Floor register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor <= prb_pkg::FLOOR_RESET;
        end else if (i_cfg_wr_en) begin
            r_floor <= i_cfg_wr_data;
        end
    end

    // Capture the atom on acceptance
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            for (int k = 0; k < NC; k++) begin
                r_f[k] <= s_axis_tdata[k*CW +: CW];
                r_g[k] <= s_axis_tdata[(NC+k)*CW +: CW];
            end
            r_last <= s_axis_tlast;
        end
    end

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_step    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            // Raise the result on emit, drop it once taken
            if ((r_state == S_EMIT) && out_free) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_step  <= '0;
                        r_state <= S_MAC;
                    end
                end
                S_MAC: begin
                    if (r_step == STEP_W'(NSTEP - 1)) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_DRAIN: begin
                    r_state <= r_last ? S_PREP : S_IDLE;
                end
                S_PREP: begin
                    r_mag    <= num_mag;
                    r_den    <= $unsigned(mac_den);
                    r_neg    <= mac_num[AW-1];
                    r_den_ok <= den_ok;
                    r_ovf    <= mac_ovf;
                    r_state  <= S_LOAD;
                end
                S_LOAD: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_beta  <= n_beta;
                        r_sat   <= n_sat;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_beta;
    assign m_axis_tuser  = r_sat;

endmodule

>>> verif/tb_polak_ribiere_beta_reduction.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polak_ribiere_beta_reduction: self-checking bench for the beta reduction
// Streams atom sets through the block and checks every beta against its
// typed value or an in-bench predictor of the saturating sums and the Q16.16
// division. A directed table covers the corners. Random sets then run under
// several floors, with random idling, a long output stall and a drained pause.
// ----------------------------------------------------------------------------
module tb_polak_ribiere_beta_reduction;

    localparam int NUM_COMP        = prb_pkg::NUM_COMP;
    localparam int COMPONENT_WIDTH = prb_pkg::COMPONENT_WIDTH;
    localparam int BETA_WIDTH      = prb_pkg::BETA_WIDTH;
    localparam int FLOOR_WIDTH     = prb_pkg::FLOOR_WIDTH;
    localparam logic [FLOOR_WIDTH-1:0] FLOOR_RESET = prb_pkg::FLOOR_RESET;
    localparam logic [BETA_WIDTH-1:0]  BETA_MAX    = prb_pkg::BETA_MAX;
    localparam logic [BETA_WIDTH-1:0]  BETA_MIN    = prb_pkg::BETA_MIN;

    localparam int  TDATA_WIDTH = 2 * NUM_COMP * COMPONENT_WIDTH;
    localparam int  STALL_CYCLES = 600;
    localparam int  SETTLE_CYCLES = 64;
    localparam logic [COMPONENT_WIDTH-1:0] Q_ONE = 32'h0001_0000;

    typedef logic [0:NUM_COMP-1][COMPONENT_WIDTH-1:0] t_vec;

    typedef struct packed {
        logic [BETA_WIDTH-1:0] beta;
        logic                  saturated;
    } t_beta_result;

    // One atom; "typed" rows carry a hand-computed beta in "want"
    typedef struct packed {
        t_vec         cur_f;
        t_vec         prev_g;
        logic         last_atom;
        logic         typed;
        t_beta_result want;
    } t_atom_row;

    localparam int N_DIRECTED = 17;

    // Directed table: corners, saturation, floor boundary, multi-atom sets
    t_atom_row directed_rows [N_DIRECTED] = '{
        // empty denominator
        '{'{0, 0, 0, 0}, '{0, 0, 0, 0}, 1'b1, 1'b1, '{32'h0, 1'b0}},
        // equal forces: numerator cancels
        '{'{Q_ONE, 0, 0, 0}, '{Q_ONE, 0, 0, 0}, 1'b1, 1'b1, '{32'h0, 1'b0}},
        // (4 - 2) / 1 = 2.0
        '{'{32'h0002_0000, 0, 0, 0}, '{Q_ONE, 0, 0, 0}, 1'b1, 1'b1,
          '{32'h0002_0000, 1'b0}},
        // two-atom set
        '{'{Q_ONE, Q_ONE, Q_ONE, Q_ONE}, '{Q_ONE, Q_ONE, Q_ONE, Q_ONE}, 1'b0, 1'b0,
          '{32'h0, 1'b0}},
        '{'{32'h0003_0000, 0, 0, 0}, '{0, 0, 0, 0}, 1'b1, 1'b0, '{32'h0, 1'b0}},
        // negative beta
        '{'{Q_ONE, 0, 0, 0}, '{32'h0003_0000, 0, 0, 0}, 1'b1, 1'b0, '{32'h0, 1'b0}},
        '{'{32'hFFFF_0000, 0, 0, 0}, '{32'h0002_0000, 0, 0, 0}, 1'b1, 1'b0,
          '{32'h0, 1'b0}},
        // numerator saturates, denominator empty
        '{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
          '{0, 0, 0, 0}, 1'b1, 1'b1, '{32'h0, 1'b1}},
        // both sums saturate: max / max = 1.0
        '{'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
          '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
          1'b1, 1'b1, '{32'h0001_0000, 1'b1}},
        // quotient beyond Q16.16 range clamps high
        '{'{32'h0100_0000, 0, 0, 0}, '{Q_ONE, 0, 0, 0}, 1'b1, 1'b1,
          '{BETA_MAX, 1'b1}},
        // denominator exactly at the reset floor
        '{'{Q_ONE, 0, 0, 0}, '{207, 10, 1, 0}, 1'b1, 1'b1, '{32'h0, 1'b0}},
        // one LSB above the floor
        '{'{Q_ONE, 0, 0, 0}, '{207, 10, 1, 1}, 1'b1, 1'b0, '{32'h0, 1'b0}},
        // tiny denominator below the floor
        '{'{1, 1, 1, 1}, '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
          1'b1, 1'b1, '{32'h0, 1'b0}},
        // alternating bit patterns across a two-atom set
        '{'{32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF, 32'hFFFF_0000},
          '{32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_0000, 32'h0000_FFFF},
          1'b0, 1'b0, '{32'h0, 1'b0}},
        '{'{32'h0001_8000, 32'h0000_4000, 32'hFFFE_C000, 32'h0000_0001},
          '{32'h0001_0000, 32'h0000_2000, 32'hFFFF_0000, 32'h0000_0003},
          1'b1, 1'b0, '{32'h0, 1'b0}},
        // near-parallel forces give a small beta
        '{'{32'h0002_0000, 32'h0001_0000, 0, 0}, '{32'h0001_F000, 32'h0001_0400, 0, 0},
          1'b1, 1'b0, '{32'h0, 1'b0}},
        '{'{32'h0000_0100, 0, 0, 0}, '{32'h0000_0200, 0, 0, 0}, 1'b1, 1'b0,
          '{32'h0, 1'b0}}
    };

    // Block ports
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_wr_en = 1'b0;
    logic [FLOOR_WIDTH-1:0] i_cfg_wr_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [TDATA_WIDTH-1:0] s_axis_tdata = '0;  // force_x..w, prev_x..w
    logic                   s_axis_tlast = 1'b0; // last_atom
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [BETA_WIDTH-1:0]  m_axis_tdata;        // beta
    logic                   m_axis_tuser;        // saturated

    // Predictor state
    logic [FLOOR_WIDTH-1:0] floor_reg = FLOOR_RESET;
    longint                 num_sum = 0;
    longint                 den_sum = 0;
    bit                     overflow_seen = 1'b0;

    t_beta_result beta_expected [$];
    int           mismatch_count = 0;
    int           atoms_offered = 0;
    bit           steady = 1'b0;
    bit           stall_req = 1'b0;
    int           stall_left = 0;

    polak_ribiere_beta_reduction uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    // Saturating 64-bit add; note any clamp for the set
    function automatic longint sat_accumulate(longint acc, longint term);
        logic [64:0] wide;
        wide = {acc[63], acc} + {term[63], term};
        if (wide[64] != wide[63]) begin
            overflow_seen = 1'b1;
            return wide[64] ? longint'(64'h8000_0000_0000_0000)
                            : longint'(64'h7FFF_FFFF_FFFF_FFFF);
        end
        return longint'(wide[63:0]);
    endfunction

    // Fold one atom into the sums; on the last atom form beta and clear
    function automatic bit absorb_atom(t_atom_row row, output t_beta_result res);
        longint      fv [NUM_COMP];
        longint      gv [NUM_COMP];
        logic [63:0] den_u;
        logic [63:0] num_u;
        logic [63:0] mag;
        logic [79:0] quo;
        logic        neg;
        for (int i = 0; i < NUM_COMP; i++) begin
            fv[i] = longint'($signed(row.cur_f[i]));
            gv[i] = longint'($signed(row.prev_g[i]));
        end
        for (int i = 0; i < NUM_COMP; i++) num_sum = sat_accumulate(num_sum, fv[i] * fv[i]);
        for (int i = 0; i < NUM_COMP; i++) num_sum = sat_accumulate(num_sum, -(gv[i] * fv[i]));
        for (int i = 0; i < NUM_COMP; i++) den_sum = sat_accumulate(den_sum, gv[i] * gv[i]);
        res = '0;
        if (!row.last_atom) return 1'b0;
        res.saturated = overflow_seen;
        den_u = den_sum;
        num_u = num_sum;
        if (den_sum > 0 && den_u > {1'b0, floor_reg}) begin
            neg = num_sum < 0;
            mag = neg ? 64'd0 - num_u : num_u;
            quo = {mag, 16'h0000} / {16'h0000, den_u};
            if (neg) begin
                if (quo > 80'h8000_0000) begin
                    res.saturated = 1'b1;
                    res.beta = BETA_MIN;
                end else begin
                    res.beta = 32'd0 - quo[31:0];
                end
            end else if (quo > 80'h7FFF_FFFF) begin
                res.saturated = 1'b1;
                res.beta = BETA_MAX;
            end else begin
                res.beta = quo[31:0];
            end
        end
        num_sum = 0;
        den_sum = 0;
        overflow_seen = 1'b0;
        return 1'b1;
    endfunction

    // Pick a component at one of several magnitude scales
    function automatic logic [COMPONENT_WIDTH-1:0] draw_component(int unsigned style);
        logic [31:0] w;
        w = $urandom;
        case (style)
            0: return w;
            1: return {{12{w[19]}}, w[19:0]};
            2: return {{7{w[24]}}, w[24:0]};
            default: return {{20{w[11]}}, w[11:0]};
        endcase
    endfunction

    task automatic flag_mismatch(string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatch_count++;
    endtask

    // Offer one atom, hold it until taken, then record what it should produce
    task automatic offer_atom(t_atom_row row);
        logic [TDATA_WIDTH-1:0] word;
        t_beta_result           res;
        while (!steady && $urandom_range(99) < 18) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        for (int i = 0; i < NUM_COMP; i++) begin
            word[COMPONENT_WIDTH*i +: COMPONENT_WIDTH] = row.cur_f[i];
            word[COMPONENT_WIDTH*(NUM_COMP+i) +: COMPONENT_WIDTH] = row.prev_g[i];
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tlast  <= row.last_atom;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        atoms_offered++;
        if (absorb_atom(row, res)) beta_expected.push_back(row.typed ? row.want : res);
    endtask

    // Build and stream one random atom set
    task automatic send_random_set();
        int unsigned n;
        int unsigned style;
        t_atom_row   row;
        n = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        style = $urandom_range(3);
        for (int a = 0; a < n; a++) begin
            row = '0;
            for (int i = 0; i < NUM_COMP; i++) begin
                row.cur_f[i] = draw_component(style);
                case ($urandom_range(2))
                    0: row.prev_g[i] = row.cur_f[i] + 32'($urandom_range(0, 511)) - 32'd256;
                    1: row.prev_g[i] = draw_component(style);
                    default: row.prev_g[i] = 32'($signed(row.cur_f[i]) >>> $urandom_range(0, 3));
                endcase
            end
            row.last_atom = (a == n - 1);
            offer_atom(row);
        end
    endtask

    // Drop valid, wait out all pending betas, then let any trailing work finish
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        while (beta_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_floor(logic [FLOOR_WIDTH-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        floor_reg = value;
    endtask

    // Result side: check each transaction, then pick the next ready level
    always @(posedge i_clk) begin
        t_beta_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (beta_expected.size() == 0) begin
                flag_mismatch($sformatf("unexpected beta %h", m_axis_tdata));
            end else begin
                want = beta_expected.pop_front();
                if (m_axis_tdata !== want.beta)
                    flag_mismatch($sformatf("beta %h, expected %h", m_axis_tdata, want.beta));
                if (m_axis_tuser !== want.saturated)
                    flag_mismatch($sformatf("saturated %b, expected %b",
                                            m_axis_tuser, want.saturated));
            end
        end
        if (stall_req) begin
            stall_left = STALL_CYCLES;
            stall_req = 1'b0;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= steady || ($urandom_range(99) >= 18);
        end
    end

    // Main sequence
    initial begin
        int goal;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table at the reset floor
        for (int r = 0; r < N_DIRECTED; r++) offer_atom(directed_rows[r]);
        settle_block();

        // Zero floor: every positive denominator divides
        write_floor('0);
        goal = atoms_offered + 100;
        while (atoms_offered < goal) send_random_set();
        settle_block();

        // Maximum floor: every beta forced to zero
        write_floor({FLOOR_WIDTH{1'b1}});
        goal = atoms_offered + 40;
        while (atoms_offered < goal) send_random_set();
        settle_block();

        // Random floor, with a run of no idling and a drained pause midway
        write_floor(FLOOR_WIDTH'($urandom) << $urandom_range(0, 31));
        goal = atoms_offered + 120;
        steady = 1'b1;
        while (atoms_offered < goal - 40) send_random_set();
        steady = 1'b0;
        settle_block();
        while (atoms_offered < goal) send_random_set();
        settle_block();

        // Back to the reset floor, under a long output stall
        write_floor(FLOOR_RESET);
        stall_req = 1'b1;
        goal = atoms_offered + 140;
        while (atoms_offered < goal) send_random_set();
        settle_block();

        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

>>> files.f
rtl/core/prb_pkg.sv
rtl/core/prb_mac.sv
rtl/core/prb_div.sv
rtl/core/polak_ribiere_beta_reduction.sv
verif/tb_polak_ribiere_beta_reduction.sv
